>>> rtl/tbg_pkg.sv
// tbg_pkg: shared types, constants and table helpers for the translation BPR gradient block.
// Used by every module under rtl/. Depends on nothing else.
package tbg_pkg;

   // Default sizes, handed down from the top level parameters
   localparam int MAX_DIM_DEF       = 64;
   localparam int TABLE_SIZE_DEF    = 1024;
   localparam int SIGMOID_RANGE_DEF = 8;

   // Field widths fixed by the item format
   localparam int ELEM_W  = 16;   // Q4.12 embedding element
   localparam int SUM_W   = 17;   // source / target
   localparam int LOSS_W  = 32;   // Q16.16 loss
   localparam int ACC_W   = 48;   // Q24.24 prediction
   localparam int GRAD_W  = 17;   // Q0.16 gradient, 1.0 included
   localparam int DIM_W   = 6;    // dimension index
   localparam int VR_W    = 30;   // prediction offset into the table range
   localparam int PROD_W  = 43;   // offset times table size
   localparam int RECIP_SH = 24;  // reciprocal scaling

   // Configuration register indexes
   localparam logic CSR_MARGIN    = 1'b0;
   localparam logic CSR_MARGIN_EN = 1'b1;

   // Controller states
   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_DRAIN = 6'b000010,
      ST_START = 6'b000100,
      ST_GWAIT = 6'b001000,
      ST_ISSUE = 6'b010000,
      ST_RWAIT = 6'b100000
   } state_type;

   // One stored dimension
   typedef struct packed {
      logic signed [SUM_W-1:0]  source;
      logic signed [SUM_W-1:0]  target;
      logic signed [LOSS_W-1:0] head_loss;
      logic signed [LOSS_W-1:0] rel_loss;
      logic signed [LOSS_W-1:0] positive_loss;
      logic signed [LOSS_W-1:0] negative_loss;
   } store_word_type;

   // Per-result control from controller to update unit
   typedef struct packed {
      logic [DIM_W-1:0] index;
      logic             last;
      logic             apply;
   } emit_ctrl_type;

   // Saturate a 34-bit sum to 32-bit signed
   function automatic logic [LOSS_W-1:0] sat32(input logic signed [LOSS_W+1:0] x);
      logic [LOSS_W-1:0] r;
      if (x > 34'sh0_7FFF_FFFF)
         r = 32'h7FFF_FFFF;
      else if (x < -34'sh0_8000_0000)
         r = 32'h8000_0000;
      else
         r = x[LOSS_W-1:0];
      return r;
   endfunction

   // Unsigned shift-subtract division, used only for elaboration-time table values
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[6'(i)]};
         if (r >= {1'b0, dvs}) begin
            r = r - {1'b0, dvs};
            q[6'(i)] = 1'b1;
         end
      end
      return q;
   endfunction

   // Sigmoid table entry idx, Q0.16, evaluated at elaboration:
   // base e^(-range/size) by a 16-term series, then powers, then 1/(1+e^-x).
   function automatic logic [15:0] sig_entry(input int idx, input int ts, input int rng);
      logic [127:0]        one;
      logic [127:0]        y;
      logic [127:0]        term;
      logic signed [127:0] acc;
      logic [127:0]        b;
      logic [127:0]        e;
      logic [127:0]        den;
      logic [127:0]        s;
      int                  d;
      int                  m;
      one  = 128'd1 << 32;
      y    = 128'(udiv64(64'(rng) << 32, 64'(ts)));
      acc  = one;
      term = one;
      for (int k = 1; k <= 16; k++) begin
         term = 128'(udiv64(64'(term * y), 64'(k) << 32));
         if ((k & 1) == 1)
            acc = acc - $signed(term);
         else
            acc = acc + $signed(term);
      end
      b = acc;
      d = 2 * idx - ts;
      m = (d < 0) ? -d : d;
      if (m > ts)
         m = ts;
      e = one;
      for (int i = 0; i < m; i++)
         e = (e * b + (128'd1 << 31)) >> 32;
      den = one + e;
      s   = 128'(udiv64(64'((128'd1 << 48) + (den >> 1)), 64'(den)));
      if (d < 0)
         s = 128'd65536 - s;
      if (s > 128'd65535)
         s = 128'd65535;
      return s[15:0];
   endfunction

endpackage

>>> rtl/tbg_store.sv
// tbg_store: dimension store, one word per dimension, one write and one registered read port.
// Depends on tbg_pkg for the word layout.
module tbg_store import tbg_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      wr_en,
   input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] wr_addr,
   input  store_word_type                            wr_data,
   input  logic                                      rd_en,
   input  logic [(MAX_DIM > 1 ? $clog2(MAX_DIM) : 1)-1:0] rd_addr,
   output logic                                      rd_valid,
   output store_word_type                            rd_data
);

   store_word_type mem [MAX_DIM];
   store_word_type rd_data_ff;
   logic           rd_valid_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset)
         rd_valid_ff <= 1'b0;
      else
         rd_valid_ff <= rd_en;
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

>>> rtl/tbg_sigmoid.sv
// tbg_sigmoid: gradient lookup, sigmoid(-prediction) from a constant table with clamping.
// Depends on tbg_pkg (widths, sig_entry). Pipelined from start to grad_valid.
module tbg_sigmoid import tbg_pkg::*; #(
   parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
   parameter int SIGMOID_RANGE = SIGMOID_RANGE_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [ACC_W-1:0]  pred,
   output logic                     grad_valid,
   output logic [GRAD_W-1:0]        grad
);

   localparam int AW = $clog2(TABLE_SIZE + 1);
   localparam logic signed [ACC_W-1:0] RANGE_Q = ACC_W'(SIGMOID_RANGE) <<< 24;
   localparam int SHIFT = 25 + $clog2(1);
   localparam logic [PROD_W-1:0] RECIP =
      PROD_W'(((64'd1 << RECIP_SH) + 64'(SIGMOID_RANGE) - 64'd1) / 64'(SIGMOID_RANGE));
   localparam logic [PROD_W-1:0] TS_Q = PROD_W'(TABLE_SIZE);

   // constant table
   logic [15:0] rom_tab [TABLE_SIZE + 1];
   for (genvar g = 0; g <= TABLE_SIZE; g++) begin : g_rom
      localparam logic [15:0] ENTRY = sig_entry(g, TABLE_SIZE, SIGMOID_RANGE);
      assign rom_tab[g] = ENTRY;
   end

   logic [5:0]              vld_ff;
   logic [4:0]              lo_ff, hi_ff;
   logic [VR_W-1:0]         vr_ff;
   logic [PROD_W-1:0]       p_ff;
   logic [PROD_W-1:0]       qm_ff;
   logic [AW-1:0]           addr_ff;
   logic [15:0]             rom_ff;
   logic [GRAD_W-1:0]       grad_ff;

   logic signed [ACC_W-1:0] v;
   logic signed [ACC_W-1:0] vr_in;
   logic [PROD_W-1:0]       q1;
   logic [PROD_W-1:0]       q_in;
   logic [AW-1:0]           addr_in;

   assign v     = -pred;
   assign vr_in = v + RANGE_Q;
   assign q1    = PROD_W'(p_ff >> SHIFT);
   assign q_in  = qm_ff >> RECIP_SH;
   assign addr_in = (q_in > TS_Q) ? AW'(TABLE_SIZE) : q_in[AW-1:0];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset)
         vld_ff <= '0;
      else
         vld_ff <= {vld_ff[4:0], start};
   end

   // stage 0: offset and range flags; stages 1-3: index = offset*size/(2*range)
   always_ff @(posedge clock) begin
      if (start) begin
         lo_ff[0] <= (v < -RANGE_Q);
         hi_ff[0] <= (v > RANGE_Q);
         vr_ff    <= vr_in[VR_W-1:0];
      end
      lo_ff[4:1] <= lo_ff[3:0];
      hi_ff[4:1] <= hi_ff[3:0];
      p_ff       <= PROD_W'(vr_ff) * TS_Q;
      qm_ff      <= q1 * RECIP;
      addr_ff    <= addr_in;
      rom_ff     <= rom_tab[addr_ff];
      // stage 5: clamp outside the table range
      if (lo_ff[4])
         grad_ff <= '0;
      else if (hi_ff[4])
         grad_ff <= GRAD_W'(65536);
      else
         grad_ff <= {1'b0, rom_ff};
   end

   assign grad_valid = vld_ff[5];
   assign grad       = grad_ff;

endmodule

>>> rtl/tbg_update.sv
// tbg_update: per-dimension loss update (gradient products, rounding, saturation)
// and the result output register. Depends on tbg_pkg.
module tbg_update import tbg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_valid,
   input  store_word_type    rd_data,
   input  logic [GRAD_W-1:0] grad,
   input  emit_ctrl_type     ctrl,
   output logic              done,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [135:0]      rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   localparam int MW = 35;

   logic                     a_vld_ff;
   logic signed [MW-1:0]     dt_ff, ds_ff;
   store_word_type           word_ff;
   logic                     out_vld_ff;
   logic [135:0]             out_data_ff;
   logic                     out_user_ff;
   logic                     out_last_ff;

   logic signed [MW-1:0]     grad_s;
   logic signed [MW-1:0]     dt_r, ds_r;
   logic signed [LOSS_W+1:0] dt_d, ds_d;
   logic [LOSS_W-1:0]        h_out, r_out, p_out, n_out;

   assign grad_s = $signed({{(MW-GRAD_W){1'b0}}, grad});

   // stage A: gradient products
   always_ff @(posedge clock) begin
      if (reset)
         a_vld_ff <= 1'b0;
      else
         a_vld_ff <= rd_valid;
   end

   always_ff @(posedge clock) begin
      if (rd_valid) begin
         dt_ff   <= grad_s * MW'(rd_data.target);
         ds_ff   <= grad_s * MW'(rd_data.source);
         word_ff <= rd_data;
      end
   end

   // stage B: round to Q16.16 (ties up), saturating adds
   assign dt_r = (dt_ff + MW'(2048)) >>> 12;
   assign ds_r = (ds_ff + MW'(2048)) >>> 12;
   assign dt_d = ctrl.apply ? (LOSS_W+2)'(dt_r) : '0;
   assign ds_d = ctrl.apply ? (LOSS_W+2)'(ds_r) : '0;
   assign h_out = sat32((LOSS_W+2)'(word_ff.head_loss) + dt_d);
   assign r_out = sat32((LOSS_W+2)'(word_ff.rel_loss) + dt_d);
   assign p_out = sat32((LOSS_W+2)'(word_ff.positive_loss) + ds_d);
   assign n_out = sat32((LOSS_W+2)'(word_ff.negative_loss) - ds_d);

   // output register
   always_ff @(posedge clock) begin
      if (reset)
         out_vld_ff <= 1'b0;
      else if (a_vld_ff)
         out_vld_ff <= 1'b1;
      else if (rsp_tready)
         out_vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (a_vld_ff) begin
         out_data_ff <= {2'b00, n_out, p_out, r_out, h_out, ctrl.index};
         out_user_ff <= ctrl.apply;
         out_last_ff <= ctrl.last;
      end
   end

   assign done       = a_vld_ff;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> rtl/translation_bpr_gradient.sv
// translation_bpr_gradient: top level, controller, dot product accumulator and config registers.
// Depends on tbg_pkg, tbg_store, tbg_sigmoid, tbg_update.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid / req_tready | req_tdata (8 fields), req_tlast = last element
//  rsp     | out | rsp_tvalid / rsp_tready | rsp_tdata (5 fields), rsp_tuser, rsp_tlast
//  csr     | in  | csr_we                  | csr_addr, csr_wdata
//
// Load: one word per cycle while req_tready is high; after the last word the block finishes
// the dot product in the pair and accumulator registers, then runs the sigmoid lookup pipeline.
// Emit: each result goes through the store read, product and rounding stages; the next store
// read is issued only once the previous result is in the result register and rsp is free.
// Reset is synchronous, active high; the store holds no reset state.
// A stalled rsp holds the result register and the next store read waits for it.
module translation_bpr_gradient import tbg_pkg::*; #(
   parameter int MAX_DIM       = MAX_DIM_DEF,
   parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
   parameter int SIGMOID_RANGE = SIGMOID_RANGE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // head, relation, positive, negative elements (16 each), then
   // head, relation, positive, negative losses (32 each)
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,
   input  logic         req_tlast,
   // dimension_index (6), head, relation, positive, negative loss out (32 each), 2 pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,
   // applied
   output logic         rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CW = $clog2(MAX_DIM + 1);

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, n_ff, k_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [SUM_W-1:0] p_src_ff, p_tgt_ff;
   logic                    p_vld_ff;
   logic signed [LOSS_W-1:0] margin_ff;
   logic                    margin_en_ff;
   logic                    apply_ff;
   logic [GRAD_W-1:0]       grad_ff;

   logic                    req_go;
   logic                    stored;
   store_word_type          wr_word;
   logic                    rd_en;
   logic                    rd_valid;
   store_word_type          rd_data;
   logic                    grad_valid;
   logic [GRAD_W-1:0]       grad_w;
   logic                    done;
   logic                    out_free;
   emit_ctrl_type           ctrl;
   logic signed [ACC_W-1:0] margin_q;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_go     = req_tvalid & req_tready;
   assign stored     = count_ff < CW'(MAX_DIM);
   assign out_free   = ~rsp_tvalid | rsp_tready;
   assign rd_en      = (state_ff == ST_ISSUE) & out_free;
   assign margin_q   = ACC_W'(margin_ff) <<< 8;

   // unpack the input word
   always_comb begin
      wr_word.source        = SUM_W'($signed(req_tdata[15:0])) +
                              SUM_W'($signed(req_tdata[31:16]));
      wr_word.target        = SUM_W'($signed(req_tdata[47:32])) -
                              SUM_W'($signed(req_tdata[63:48]));
      wr_word.head_loss     = req_tdata[95:64];
      wr_word.rel_loss      = req_tdata[127:96];
      wr_word.positive_loss = req_tdata[159:128];
      wr_word.negative_loss = req_tdata[191:160];
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff    <= '0;
         margin_en_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MARGIN:    margin_ff    <= csr_wdata;
            CSR_MARGIN_EN: margin_en_ff <= csr_wdata[0];
            default:       margin_ff    <= margin_ff;
         endcase
      end
   end

   // controller
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (req_go && req_tlast) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_START;
         ST_START: state_in = ST_GWAIT;
         ST_GWAIT: if (grad_valid) state_in = ST_ISSUE;
         ST_ISSUE: if (out_free) state_in = ST_RWAIT;
         ST_RWAIT: begin
            if (done)
               state_in = (k_ff == n_ff - CW'(1)) ? ST_LOAD : ST_ISSUE;
         end
         default:  state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_LOAD;
      else
         state_ff <= state_in;
   end

   // element count, run length and result index
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         n_ff     <= '0;
         k_ff     <= '0;
      end else begin
         if (req_go) begin
            if (req_tlast) begin
               count_ff <= '0;
               n_ff     <= stored ? count_ff + CW'(1) : count_ff;
            end else if (stored) begin
               count_ff <= count_ff + CW'(1);
            end
         end
         if (state_ff == ST_START)
            k_ff <= '0;
         else if (state_ff == ST_RWAIT && done)
            k_ff <= k_ff + CW'(1);
      end
   end

   // dot product: register the pair, then multiply-accumulate
   always_ff @(posedge clock) begin
      if (reset)
         p_vld_ff <= 1'b0;
      else
         p_vld_ff <= req_go & stored;
   end

   always_ff @(posedge clock) begin
      p_src_ff <= wr_word.source;
      p_tgt_ff <= wr_word.target;
   end

   always_ff @(posedge clock) begin
      if (reset)
         acc_ff <= '0;
      else if (state_ff == ST_START)
         acc_ff <= '0;
      else if (p_vld_ff)
         acc_ff <= acc_ff + ACC_W'(p_src_ff * p_tgt_ff);
   end

   // margin decision and gradient capture
   always_ff @(posedge clock) begin
      if (state_ff == ST_START)
         apply_ff <= ~(margin_en_ff && (acc_ff > margin_q));
      if (grad_valid)
         grad_ff <= grad_w;
   end

   assign ctrl.index = DIM_W'(k_ff);
   assign ctrl.last  = (k_ff == n_ff - CW'(1));
   assign ctrl.apply = apply_ff;

   tbg_store #(.MAX_DIM(MAX_DIM)) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_go & stored),
      .wr_addr  (count_ff[AW-1:0]),
      .wr_data  (wr_word),
      .rd_en    (rd_en),
      .rd_addr  (k_ff[AW-1:0]),
      .rd_valid (rd_valid),
      .rd_data  (rd_data)
   );

   tbg_sigmoid #(.TABLE_SIZE(TABLE_SIZE), .SIGMOID_RANGE(SIGMOID_RANGE)) u_sigmoid (
      .clock      (clock),
      .reset      (reset),
      .start      (state_ff == ST_START),
      .pred       (acc_ff),
      .grad_valid (grad_valid),
      .grad       (grad_w)
   );

   tbg_update u_update (
      .clock      (clock),
      .reset      (reset),
      .rd_valid   (rd_valid),
      .rd_data    (rd_data),
      .grad       (grad_ff),
      .ctrl       (ctrl),
      .done       (done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> verif/tb_translation_bpr_gradient.sv
// tb_translation_bpr_gradient: self-checking bench for the translation BPR gradient block.
// Drives runs of embedding words, predicts the updated losses and checks every result word.
// Depends on tbg_pkg and translation_bpr_gradient.
module tb_translation_bpr_gradient;
   import tbg_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] head, rel, pos, neg;
      logic signed [31:0] head_loss, rel_loss, pos_loss, neg_loss;
      logic               last;
   } dim_word_type;

   typedef struct {
      logic [5:0]  dim;
      logic [31:0] head_loss, rel_loss, pos_loss, neg_loss;
      logic        applied;
      logic        last;
   } loss_update_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 1'b0;
   logic         csr_addr = 1'b0;
   logic [31:0]  csr_wdata = '0;

   translation_bpr_gradient i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   dim_word_type    word_q[$];
   loss_update_type update_q[$];
   dim_word_type    cur_word;
   int              send_idle = 0;
   int              recv_idle = 0;
   int              errors = 0;
   int              cycles = 0;

   // predictor state
   logic [15:0]        sig_rom[0:1024];
   logic signed [31:0] src_mem[0:63], tgt_mem[0:63];
   logic signed [31:0] hl_mem[0:63], rl_mem[0:63], pl_mem[0:63], nl_mem[0:63];
   int                 dim_count = 0;
   longint             dot_sum = 0;
   longint             margin_q = 0;
   bit                 margin_on = 0;

   // sigmoid ROM in Q0.16, built by integer arithmetic
   task automatic build_sigmoid();
      logic [127:0] one, y, term, b, den, s;
      logic [127:0] pw[0:1024];
      longint       acc;
      int           d, m;
      one  = 128'd1 << 32;
      y    = (128'd8 << 32) / 128'd1024;
      acc  = 64'sd1 << 32;
      term = one;
      for (int k = 1; k <= 16; k++) begin
         term = (term * y) / (128'(k) << 32);
         if (k % 2) acc -= longint'(term);
         else acc += longint'(term);
      end
      b = 128'(acc);
      pw[0] = one;
      for (int i = 1; i <= 1024; i++)
         pw[11'(i)] = (pw[11'(i-1)] * b + (128'd1 << 31)) >> 32;
      for (int i = 0; i <= 1024; i++) begin
         d   = 2 * i - 1024;
         m   = (d < 0) ? -d : d;
         den = one + pw[11'(m)];
         s   = ((128'd1 << 48) + den / 2) / den;
         if (d < 0) s = 128'd65536 - s;
         if (s > 128'd65535) s = 128'd65535;
         sig_rom[11'(i)] = s[15:0];
      end
   endtask

   function automatic logic [31:0] sat_sum(longint loss, longint delta);
      longint r;
      r = loss + delta;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   // accept one dimension word; on the last one emit every stored dimension
   task automatic predict_losses(dim_word_type w);
      longint src, tgt, v, r, grad, dt, ds;
      bit     apply;
      logic [5:0]  slot;
      logic [10:0] idx;
      loss_update_type u;
      if (dim_count < 64) begin
         slot = 6'(dim_count);
         src = longint'(w.head) + longint'(w.rel);
         tgt = longint'(w.pos) - longint'(w.neg);
         src_mem[slot] = 32'(src);
         tgt_mem[slot] = 32'(tgt);
         hl_mem[slot] = w.head_loss;
         rl_mem[slot] = w.rel_loss;
         pl_mem[slot] = w.pos_loss;
         nl_mem[slot] = w.neg_loss;
         dot_sum += src * tgt;
         dim_count++;
      end
      if (!w.last) return;
      apply = !(margin_on && dot_sum > margin_q * 256);
      v = -dot_sum;
      r = 64'sd8 << 24;
      if (v < -r) grad = 0;
      else if (v > r) grad = 65536;
      else begin
         idx  = 11'(((v + r) * 1024) / (2 * r));
         grad = longint'(sig_rom[idx]);
      end
      for (int k = 0; k < dim_count; k++) begin
         slot = 6'(k);
         dt = apply ? ((grad * longint'(tgt_mem[slot]) + 2048) >>> 12) : 0;
         ds = apply ? ((grad * longint'(src_mem[slot]) + 2048) >>> 12) : 0;
         u.dim       = slot;
         u.head_loss = sat_sum(hl_mem[slot], dt);
         u.rel_loss  = sat_sum(rl_mem[slot], dt);
         u.pos_loss  = sat_sum(pl_mem[slot], ds);
         u.neg_loss  = sat_sum(nl_mem[slot], -ds);
         u.applied   = apply;
         u.last      = (k == dim_count - 1);
         update_q.push_back(u);
      end
      dim_count = 0;
      dot_sum = 0;
   endtask

   // driver: feeds words, predicts on each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_losses(cur_word);
         if (!req_tvalid || req_tready) begin
            if (word_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
               cur_word = word_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {cur_word.neg_loss, cur_word.pos_loss, cur_word.rel_loss,
                             cur_word.head_loss, cur_word.neg, cur_word.pos, cur_word.rel,
                             cur_word.head};
               req_tlast <= cur_word.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result word with the oldest expected update
   always @(posedge clock) begin
      loss_update_type e;
      cycles++;
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (update_q.size() == 0) begin
            $display("%0t: unexpected result word %h", $realtime, rsp_tdata);
            errors++;
         end else begin
            e = update_q.pop_front();
            if (rsp_tdata[5:0] !== e.dim || rsp_tdata[37:6] !== e.head_loss ||
                rsp_tdata[69:38] !== e.rel_loss || rsp_tdata[101:70] !== e.pos_loss ||
                rsp_tdata[133:102] !== e.neg_loss || rsp_tuser !== e.applied ||
                rsp_tlast !== e.last) begin
               $display("%0t: mismatch exp dim %0d %h %h %h %h app %b last %b", $realtime,
                        e.dim, e.head_loss, e.rel_loss, e.pos_loss, e.neg_loss,
                        e.applied, e.last);
               $display("%0t:          got dim %0d %h %h %h %h app %b last %b", $realtime,
                        rsp_tdata[5:0], rsp_tdata[37:6], rsp_tdata[69:38],
                        rsp_tdata[101:70], rsp_tdata[133:102], rsp_tuser, rsp_tlast);
               errors++;
            end
         end
      end
      if (cycles > 600000) begin
         $display("tb_translation_bpr_gradient failed");
         $finish;
      end
   end

   function automatic logic [15:0] rand_elem();
      return 16'($signed(16'($urandom)) >>> $urandom_range(0, 15));
   endfunction

   function automatic logic [31:0] rand_loss();
      case ($urandom_range(0, 3))
         0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
         1: return 32'h8000_0000 + $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic push_word(logic [15:0] e, logic [31:0] l, bit last);
      dim_word_type w;
      w.head = e; w.rel = e; w.pos = e; w.neg = ~e;
      w.head_loss = l; w.rel_loss = l; w.pos_loss = l; w.neg_loss = l;
      w.last = last;
      word_q.push_back(w);
   endtask

   task automatic push_run(int len);
      dim_word_type w;
      for (int i = 0; i < len; i++) begin
         w.head = rand_elem(); w.rel = rand_elem();
         w.pos = rand_elem(); w.neg = rand_elem();
         w.head_loss = rand_loss(); w.rel_loss = rand_loss();
         w.pos_loss = rand_loss(); w.neg_loss = rand_loss();
         w.last = (i == len - 1);
         word_q.push_back(w);
      end
   endtask

   task automatic write_csr(logic idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MARGIN) margin_q = longint'($signed(val));
      else margin_on = val[0];
   endtask

   task automatic drain();
      while (word_q.size() > 0 || req_tvalid || update_q.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      build_sigmoid();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, zero, tiny values, a two-dim run, then a random three-dim run
      push_word(16'h7FFF, 32'h7FFF_FFFF, 1);
      push_word(16'h8000, 32'h8000_0000, 1);
      push_word(16'h0000, 32'h0000_0000, 1);
      push_word(16'h0001, 32'h0000_0001, 1);
      push_word(16'hFFFF, 32'hFFFF_FFFF, 0);
      push_word(16'h0010, 32'h1234_5678, 1);
      push_run(3);
      drain();

      // margin variant, threshold zero then the extremes
      write_csr(CSR_MARGIN_EN, 32'd1);
      write_csr(CSR_MARGIN, 32'd0);
      push_word(16'h7FFF, 32'h7FFF_FFFF, 1);
      push_word(16'h0004, 32'h0000_0100, 1);
      push_run(4);
      drain();
      write_csr(CSR_MARGIN, 32'h7FFF_FFFF);
      push_run(3);
      drain();
      write_csr(CSR_MARGIN, 32'h8000_0000);
      push_run(3);
      drain();

      // random runs over idle profiles and settings, plus one 66-dim run past the store depth
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 78; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 78; end
            default: begin send_idle = 9; recv_idle = 9; end
         endcase
         write_csr(CSR_MARGIN_EN, 32'(ph % 2));
         write_csr(CSR_MARGIN, (ph == 2) ? 32'h0000_8000 : $urandom);
         for (int n = 0; n < 8; n++)
            push_run($urandom_range(1, 4));
         if (ph == 3) push_run(66);
         drain();
      end

      if (errors == 0)
         $display("tb_translation_bpr_gradient passed");
      else
         $display("tb_translation_bpr_gradient failed");
      $finish;
   end
endmodule

>>> files.f
rtl/tbg_pkg.sv
rtl/tbg_store.sv
rtl/tbg_sigmoid.sv
rtl/tbg_update.sv
rtl/translation_bpr_gradient.sv
verif/tb_translation_bpr_gradient.sv
